// File: design/smud_pkg.sv
package smud_pkg;

    // Data path width and default store depth
    localparam int ELEM_W        = 32;
    localparam int SET_DEPTH_DEF = 32;

    // Input kind codes
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // Set operation codes
    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_INTER = 2'd1;
    localparam logic [1:0] OP_DIFF  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_RUN_FETCH,
        ST_RUN_STEP,
        ST_RUN_END
    } t_state;

    // Result of the shared signed comparator
    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_res;

endpackage

// File: design/smud_ram.sv
module smud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/smud_cmp.sv
module smud_cmp (
    input  logic [smud_pkg::ELEM_W-1:0] i_lhs,
    input  logic [smud_pkg::ELEM_W-1:0] i_rhs,
    output smud_pkg::t_cmp_res          o_res
);

    import smud_pkg::*;

    // Two's-complement ordering of the two operands
    always_comb begin
        o_res.lt = $signed(i_lhs) < $signed(i_rhs);
        o_res.gt = $signed(i_lhs) > $signed(i_rhs);
    end

endmodule

// File: design/sorted_multiset_union_intersect_diff_unit.sv
// Sorted multiset union / intersection / difference unit. Load transactions (kind 0 into
// set A, kind 1 into set B) keep each set sorted ascending by insertion; a load into a full
// set is dropped and sets the overflow flag, which overflow_seen shows on the next run's
// results. A run transaction (kind 2) merges both sets under the set_operation register
// (0 union, 1 intersection, 2 A minus B, 3 gives an empty result) and sends the result
// ascending, one value per output transaction, final_item marking the last one; an empty
// result is a single transaction with has_value low. Both sets and the overflow flag are
// cleared at the end of a run. An insertion shifts each larger stored value up one slot;
// a run takes at most count_a + count_b merge steps and also holds while the output is
// stalled. Both are paced by the single registered read port of each set RAM and the one
// shared comparator, and the input is stalled until they finish.
module sorted_multiset_union_intersect_diff_unit #(
    parameter int SET_DEPTH = smud_pkg::SET_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [smud_pkg::ELEM_W-1:0] i_element,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [smud_pkg::ELEM_W-1:0] o_result_value,
    output logic                        o_has_value,
    output logic                        o_final_item,
    output logic                        o_overflow_seen,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_wr_data
);

    import smud_pkg::*;

    localparam int IW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    // Control registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt_a, n_cnt_a;
    logic [CW-1:0]   r_cnt_b, n_cnt_b;
    logic            r_drop, n_drop;
    logic [1:0]      r_op;
    logic            r_pend_valid, n_pend_valid;
    logic            r_out_valid, n_out_valid;

    // Payload registers
    logic              r_sel, n_sel;
    logic [ELEM_W-1:0] r_elem, n_elem;
    logic [IW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [ELEM_W-1:0] r_pend_value, n_pend_value;
    logic [ELEM_W-1:0] r_out_value, n_out_value;
    logic              r_out_has, n_out_has;
    logic              r_out_final, n_out_final;
    logic              r_out_ovf, n_out_ovf;

    // RAM ports
    logic              we_a, we_b;
    logic [IW-1:0]     waddr;
    logic [ELEM_W-1:0] wdata;
    logic [IW-1:0]     raddr_a, raddr_b;
    logic [ELEM_W-1:0] rdata_a, rdata_b;

    // Shared comparator
    logic [ELEM_W-1:0] cmp_lhs, cmp_rhs;
    t_cmp_res          cmp_res;

    // Merge decode
    logic          run_mode;
    logic [IW-1:0] pos_m1;
    logic [CW-1:0] load_cnt;
    logic          a_more, b_more, take_a, take_b, emit, out_free;

    smud_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    smud_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    smud_cmp u_cmp (
        .i_lhs (cmp_lhs),
        .i_rhs (cmp_rhs),
        .o_res (cmp_res)
    );

    // Read addresses: merge indices during a run, insertion scan otherwise
    assign run_mode = (r_state == ST_RUN_FETCH) || (r_state == ST_RUN_STEP);
    assign pos_m1   = r_pos - IW'(1);
    assign raddr_a  = run_mode ? r_i[IW-1:0] : pos_m1;
    assign raddr_b  = run_mode ? r_j[IW-1:0] : pos_m1;

    // Comparator operands: A against B in a run, stored value against new value on insert
    assign cmp_lhs = (run_mode || !r_sel) ? rdata_a : rdata_b;
    assign cmp_rhs = run_mode ? rdata_b : r_elem;

    // Merge step decision
    assign a_more   = r_i < r_cnt_a;
    assign b_more   = r_j < r_cnt_b;
    assign take_a   = !b_more || (a_more && cmp_res.lt);
    assign take_b   = !take_a && (!a_more || cmp_res.gt);
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_cnt = (i_kind == KIND_LOAD_B) ? r_cnt_b : r_cnt_a;

    always_comb begin
        priority if (take_a) begin
            emit = (r_op == OP_UNION) || (r_op == OP_DIFF);
        end else if (take_b) begin
            emit = (r_op == OP_UNION);
        end else begin
            emit = (r_op == OP_UNION) || (r_op == OP_INTER);
        end
    end

    // Sequencer: next state, RAM writes and output register
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_drop       = r_drop;
        n_pend_valid = r_pend_valid;
        n_sel        = r_sel;
        n_elem       = r_elem;
        n_pos        = r_pos;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_has    = r_out_has;
        n_out_final  = r_out_final;
        n_out_ovf    = r_out_ovf;
        we_a         = 1'b0;
        we_b         = 1'b0;
        waddr        = r_pos;
        wdata        = r_elem;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_kind == KIND_LOAD_A || i_kind == KIND_LOAD_B) begin
                        if (load_cnt == CW'(SET_DEPTH)) begin
                            n_drop = 1'b1;
                        end else begin
                            if (i_kind == KIND_LOAD_B) begin
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                            if (load_cnt == '0) begin
                                // first value: store directly at the head
                                we_a  = (i_kind == KIND_LOAD_A);
                                we_b  = (i_kind == KIND_LOAD_B);
                                waddr = '0;
                                wdata = i_element;
                            end else begin
                                n_sel   = (i_kind == KIND_LOAD_B);
                                n_elem  = i_element;
                                n_pos   = load_cnt[IW-1:0];
                                n_state = ST_INS_READ;
                            end
                        end
                    end else if (i_kind == KIND_RUN) begin
                        n_i          = '0;
                        n_j          = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_RUN_FETCH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_INS_READ: begin
                n_state = ST_INS_CMP;
            end

            ST_INS_CMP: begin
                we_a  = !r_sel;
                we_b  = r_sel;
                waddr = r_pos;
                if (cmp_res.gt) begin
                    // shift the larger value up one slot and keep scanning, or put the new value at the head
                    wdata = cmp_lhs;
                    n_pos = pos_m1;
                    n_state = (r_pos == IW'(1)) ? ST_INS_PUT : ST_INS_READ;
                end else begin
                    wdata   = r_elem;
                    n_state = ST_IDLE;
                end
            end

            ST_INS_PUT: begin
                we_a    = !r_sel;
                we_b    = r_sel;
                waddr   = '0;
                wdata   = r_elem;
                n_state = ST_IDLE;
            end

            ST_RUN_FETCH: begin
                if ((a_more || b_more) && r_op != OP_NONE) begin
                    n_state = ST_RUN_STEP;
                end else begin
                    n_state = ST_RUN_END;
                end
            end

            ST_RUN_STEP: begin
                // hold while a pending value cannot be handed to the output register
                if (!(emit && r_pend_valid && !out_free)) begin
                    if (emit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_value = r_pend_value;
                            n_out_has   = 1'b1;
                            n_out_final = 1'b0;
                            n_out_ovf   = r_drop;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_value = take_b ? rdata_b : rdata_a;
                    end
                    if (!take_b) begin
                        n_i = r_i + CW'(1);
                    end
                    if (!take_a) begin
                        n_j = r_j + CW'(1);
                    end
                    n_state = ST_RUN_FETCH;
                end
            end

            ST_RUN_END: begin
                if (out_free) begin
                    // last transaction of the run, or the empty marker
                    n_out_valid  = 1'b1;
                    n_out_value  = r_pend_valid ? r_pend_value : '0;
                    n_out_has    = r_pend_valid;
                    n_out_final  = 1'b1;
                    n_out_ovf    = r_drop;
                    n_pend_valid = 1'b0;
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_drop       = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_drop       <= 1'b0;
            r_op         <= OP_UNION;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_drop       <= n_drop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_op <= i_cfg_wr_data;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_elem       <= n_elem;
        r_pos        <= n_pos;
        r_i          <= n_i;
        r_j          <= n_j;
        r_pend_value <= n_pend_value;
        r_out_value  <= n_out_value;
        r_out_has    <= n_out_has;
        r_out_final  <= n_out_final;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_has_value     = r_out_has;
    assign o_final_item    = r_out_final;
    assign o_overflow_seen = r_out_ovf;

endmodule

// File: design/smud_checker.sv
module smud_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [1:0]                  i_kind,
    input logic [smud_pkg::ELEM_W-1:0] i_element,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [smud_pkg::ELEM_W-1:0] o_result_value,
    input logic                        o_has_value,
    input logic                        o_final_item,
    input logic                        o_overflow_seen,
    input logic                        i_cfg_wr_en,
    input logic [1:0]                  i_cfg_wr_data
);

    import smud_pkg::*;

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_final_item))
        else $error("result transaction changed while stalled");

    // An empty result is always the last of its run
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_value |-> o_final_item)
        else $error("empty result not marked final");

    // An empty result carries a zero value
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_value |-> o_result_value == '0)
        else $error("empty result carries a value");

    // A run transaction blocks the input while the merge proceeds
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == KIND_RUN |=> o_in_stall)
        else $error("input accepted right after a run transaction");

endmodule

bind sorted_multiset_union_intersect_diff_unit smud_checker u_smud_checker (.*);
